/* rtl/cstk_pkg.sv */
// shared types and constants for the cosine similarity top-k search block
package cstk_pkg;

  localparam int CSTK_MAX_DIM     = 64;
  localparam int CSTK_MAX_ENTRIES = 256;
  localparam int CSTK_MAX_K       = 64;
  localparam int ELEM_W           = 16;
  localparam int ID_W             = 32;
  localparam int NORM_W           = 24;
  localparam int SQ_W             = 40;
  localparam int SQRT_STEPS       = SQ_W / 2;
  localparam int FRAC_BITS        = 15;
  localparam int REM_W            = 50;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_MATCH    = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic REG_VLEN  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [6:0] VLEN_RESET  = 7'd64;
  localparam logic [8:0] LIMIT_RESET = 9'd256;

  typedef struct packed {
    logic                     action;
    logic signed [ELEM_W-1:0] element_value;
    logic                     last_element;
    logic signed [ID_W-1:0]   entry_id;
    logic [6:0]               top_k;
  } req_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [ID_W-1:0]   match_id;
    logic signed [ELEM_W-1:0] match_score;
    logic                     last_result;
  } rsp_t;

endpackage

/* rtl/cosine_similarity_top_k_search.sv */
// top level of the cosine similarity top-k search block
//
// request channel: an element is taken when start is high and busy is low.
// elements of a vector arrive one per cycle while not busy; the last element
// of an add or a query makes the block busy while it finishes that vector.
// result channel: result_valid marks each result for exactly one cycle.
// an add answers one status after the norm square root, then the store.
// a query scans every stored entry through one shared multiply-accumulate
// and one shared restoring divider, then sends out each reported match.
// matches come out best score first, the last one flagged.
// the user must send configuration over the apb port only while the block
// is idle; the block does not enforce it.
// reset empties the index and restores vector_length 64, entry_limit 256.
// the receiver cannot stall; results are never held back.
module cosine_similarity_top_k_search import cstk_pkg::*; #(
  parameter int MAX_DIM     = CSTK_MAX_DIM,
  parameter int MAX_ENTRIES = CSTK_MAX_ENTRIES,
  parameter int MAX_K       = CSTK_MAX_K
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        request,
  output logic        result_valid,
  output rsp_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int POS_W  = $clog2(MAX_DIM + 1);
  localparam int DIM_AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int VS_D   = MAX_ENTRIES * MAX_DIM;
  localparam int VS_AW  = (VS_D > 1) ? $clog2(VS_D) : 1;
  localparam int K_CW   = $clog2(MAX_K + 1);
  localparam int K_AW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int ACC_W  = 2 * ELEM_W + DIM_AW + 1;
  localparam int DEN_W  = 2 * NORM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_DECIDE, S_DOT, S_DEN, S_CHK, S_DIV, S_FIN, S_INS,
    S_OUT_RD, S_OUT
  } state_t;

  state_t state;

  logic [6:0] vector_length;
  logic [8:0] entry_limit;

  logic [POS_W-1:0] pos;
  logic             len_err;
  logic [SQ_W-1:0]  sq_sum;
  logic [CNT_W-1:0] entry_count;

  logic             act_q;
  logic [ID_W-1:0]  id_in;
  logic [6:0]       want;
  logic             mism;

  logic [SQ_W-1:0]  sq_v;
  logic [SQ_W-1:0]  sq_r;
  logic [SQ_W-1:0]  sq_bit;
  logic [4:0]       sq_cnt;
  logic [NORM_W-1:0] qn;

  logic [K_CW-1:0]  k_lim;
  logic [K_CW-1:0]  fill;
  logic [CNT_W-1:0] ei;
  logic [POS_W-1:0] ja;
  logic             rv;
  logic             pv;
  logic signed [ELEM_W-1:0]   qb_q;
  logic signed [ELEM_W-1:0]   vs_q;
  logic signed [2*ELEM_W-1:0] prod;
  logic signed [ACC_W-1:0]    acc;
  logic [NORM_W-1:0] en_q;
  logic [DEN_W-1:0]  den;
  logic              neg;
  logic [REM_W-1:0]  rem;
  logic [FRAC_BITS-1:0] quo;
  logic [3:0]        dcnt;
  logic signed [ELEM_W-1:0] score;

  logic signed [ELEM_W-1:0] best_s [MAX_K];
  logic [ENT_AW-1:0]        best_i [MAX_K];
  logic [K_CW-1:0]          oi;
  logic [ID_W-1:0]          id_q;

  logic signed [ELEM_W-1:0] qbuf   [MAX_DIM];
  logic signed [ELEM_W-1:0] vstore [VS_D];
  logic [NORM_W-1:0]        nstore [MAX_ENTRIES];
  logic [ID_W-1:0]          istore [MAX_ENTRIES];

  logic                       accept;
  logic                       pos_ok;
  logic signed [2*ELEM_W-1:0] e_sq;
  logic [SQ_W-1:0]            sq_next;
  logic [POS_W-1:0]           pos_next;
  logic                       err_next;
  logic [SQ_W-1:0]            sq_rb;
  logic                       is_full;
  logic                       add_ok;
  logic [K_CW-1:0]            kk;
  logic [ACC_W-1:0]           mag;
  logic [REM_W-1:0]           rem2;
  logic                       dot_done;
  logic                       ge [MAX_K];
  logic [VS_AW-1:0]           wr_addr;
  logic [VS_AW-1:0]           rd_addr;
  logic                       cfg_wr;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = (paddr[2] == REG_LIMIT) ? 32'(entry_limit) : 32'(vector_length);
  end

  always_comb begin
    int w;
    pos_ok   = (32'(pos) < MAX_DIM);
    e_sq     = request.element_value * request.element_value;
    sq_next  = pos_ok ? SQ_W'(sq_sum + SQ_W'($unsigned(e_sq))) : sq_sum;
    pos_next = pos_ok ? POS_W'(pos + 1'b1) : pos;
    err_next = len_err || !pos_ok;
    sq_rb    = sq_r + sq_bit;
    is_full  = (32'(entry_count) >= MAX_ENTRIES) ||
               (32'(entry_count) >= 32'(entry_limit));
    add_ok   = (state == S_DECIDE) && (act_q == ACT_ADD) && !mism && !is_full;
    w = (want == 7'd0) ? 1 : 32'(want);
    if (w > MAX_K) w = MAX_K;
    if (w > 32'(entry_count)) w = 32'(entry_count);
    kk       = K_CW'(w);
    mag      = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    rem2     = {rem[REM_W-2:0], 1'b0};
    dot_done = (32'(ja) == 32'(vector_length)) && !rv && !pv;
    wr_addr  = VS_AW'(32'(entry_count) * MAX_DIM + 32'(pos));
    rd_addr  = VS_AW'(32'(ei) * MAX_DIM + 32'(ja));
    for (int j = 0; j < MAX_K; j++) begin
      ge[j] = (32'(j) < 32'(fill)) && (best_s[j] >= score);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos_ok) begin
      qbuf[pos[DIM_AW-1:0]] <= request.element_value;
      if (32'(entry_count) < MAX_ENTRIES) begin
        vstore[wr_addr] <= request.element_value;
      end
    end
    if (add_ok) begin
      nstore[entry_count[ENT_AW-1:0]] <= sq_r[NORM_W-1:0];
      istore[entry_count[ENT_AW-1:0]] <= id_in;
    end
    if (state == S_DOT) begin
      qb_q <= qbuf[ja[DIM_AW-1:0]];
      vs_q <= vstore[rd_addr];
      en_q <= nstore[ei[ENT_AW-1:0]];
    end
    if (state == S_OUT_RD) begin
      id_q <= istore[best_i[oi[K_AW-1:0]]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vector_length <= VLEN_RESET;
      entry_limit   <= LIMIT_RESET;
      pos           <= '0;
      len_err       <= 1'b0;
      sq_sum        <= '0;
      entry_count   <= '0;
      result_valid  <= 1'b0;
      fill          <= '0;
      rv            <= 1'b0;
      pv            <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_wr) begin
        case (paddr[2])
          REG_VLEN:  vector_length <= pwdata[6:0];
          REG_LIMIT: entry_limit   <= pwdata[8:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (request.last_element) begin
              mism    <= err_next || (32'(pos_next) != 32'(vector_length));
              act_q   <= request.action;
              id_in   <= request.entry_id;
              want    <= request.top_k;
              sq_v    <= sq_next;
              sq_r    <= '0;
              sq_bit  <= SQ_W'(1) << (SQ_W - 2);
              sq_cnt  <= '0;
              pos     <= '0;
              len_err <= 1'b0;
              sq_sum  <= '0;
              state   <= S_SQRT;
            end else begin
              pos     <= pos_next;
              len_err <= err_next;
              sq_sum  <= sq_next;
            end
          end
        end
        S_SQRT: begin
          if (sq_v >= sq_rb) begin
            sq_v <= sq_v - sq_rb;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 5'd1;
          if (32'(sq_cnt) == SQRT_STEPS - 1) state <= S_DECIDE;
        end
        S_DECIDE: begin
          qn <= sq_r[NORM_W-1:0];
          result_valid <= 1'b1;
          result <= '{status: ST_ADDED, match_id: '0, match_score: '0,
                      last_result: 1'b1};
          state <= S_IDLE;
          if (mism) begin
            result.status <= ST_MISMATCH;
          end else if (act_q == ACT_ADD) begin
            if (is_full) begin
              result.status <= ST_FULL;
            end else begin
              entry_count <= entry_count + 1'b1;
            end
          end else if (entry_count == '0) begin
            result.status <= ST_EMPTY;
          end else begin
            result_valid <= 1'b0;
            k_lim <= kk;
            fill  <= '0;
            ei    <= '0;
            ja    <= '0;
            acc   <= '0;
            rv    <= 1'b0;
            pv    <= 1'b0;
            state <= S_DOT;
          end
        end
        S_DOT: begin
          rv   <= (32'(ja) < 32'(vector_length));
          if (32'(ja) < 32'(vector_length)) ja <= ja + 1'b1;
          prod <= qb_q * vs_q;
          pv   <= rv;
          if (pv) acc <= acc + ACC_W'(prod);
          if (dot_done) state <= S_DEN;
        end
        S_DEN: begin
          den   <= qn * en_q;
          neg   <= acc[ACC_W-1];
          rem   <= REM_W'(mag);
          state <= S_CHK;
        end
        S_CHK: begin
          if (qn == '0 || en_q == '0) begin
            score <= '0;
            state <= S_INS;
          end else if (rem >= REM_W'(den)) begin
            score <= neg ? 16'sh8000 : 16'sh7fff;
            state <= S_INS;
          end else begin
            quo   <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2 >= REM_W'(den)) begin
            rem <= rem2 - REM_W'(den);
            quo <= {quo[FRAC_BITS-2:0], 1'b1};
          end else begin
            rem <= rem2;
            quo <= {quo[FRAC_BITS-2:0], 1'b0};
          end
          dcnt <= dcnt + 4'd1;
          if (32'(dcnt) == FRAC_BITS - 1) state <= S_FIN;
        end
        S_FIN: begin
          score <= neg ? ELEM_W'(-{1'b0, quo}) : ELEM_W'({1'b0, quo});
          state <= S_INS;
        end
        S_INS: begin
          for (int j = 0; j < MAX_K; j++) begin
            if (!ge[j]) begin
              if (j == 0 || ge[(j > 0) ? j - 1 : 0]) begin
                best_s[j] <= score;
                best_i[j] <= ei[ENT_AW-1:0];
              end else begin
                best_s[j] <= best_s[(j > 0) ? j - 1 : 0];
                best_i[j] <= best_i[(j > 0) ? j - 1 : 0];
              end
            end
          end
          if (fill != k_lim) fill <= fill + 1'b1;
          ei  <= ei + 1'b1;
          ja  <= '0;
          acc <= '0;
          rv  <= 1'b0;
          pv  <= 1'b0;
          if (CNT_W'(ei + 1'b1) == entry_count) begin
            oi    <= '0;
            state <= S_OUT_RD;
          end else begin
            state <= S_DOT;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          result_valid <= 1'b1;
          result <= '{status: ST_MATCH, match_id: id_q,
                      match_score: best_s[oi[K_AW-1:0]],
                      last_result: (K_CW'(oi + 1'b1) == fill)};
          oi <= oi + 1'b1;
          state <= (K_CW'(oi + 1'b1) == fill) ? S_IDLE : S_OUT_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_MATCH) |-> result.last_result)
    else $error("status result without last flag");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    32'(entry_count) <= MAX_ENTRIES)
    else $error("entry count above capacity");

  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS || state == S_OUT) |-> fill <= k_lim)
    else $error("match list longer than k");

  a_quiet_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_DOT || state == S_DIV) |=> !result_valid)
    else $error("result during scan");

endmodule

/* tb/cstk_checker.sv */
// checker: predicts the top-k search results from the observed requests and compares them
`timescale 1ns / 1ps
module cstk_checker import cstk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  req_t        request,
  input  logic        result_valid,
  input  rsp_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          results_seen
);

  logic signed [ELEM_W-1:0] vec_mem [CSTK_MAX_ENTRIES*CSTK_MAX_DIM];
  logic [NORM_W-1:0]        norm_mem [CSTK_MAX_ENTRIES];
  logic [ID_W-1:0]          id_mem [CSTK_MAX_ENTRIES];
  logic signed [ELEM_W-1:0] qbuf [CSTK_MAX_DIM];
  int unsigned              n_entries;
  int unsigned              pos;
  bit                       len_err;
  logic [SQ_W-1:0]          sq_acc;
  logic [6:0]               vlen_q;
  logic [8:0]               limit_q;
  rsp_t                     rsp_due [$];
  int                       err_cnt;
  int                       rsp_cnt;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int cosine_q15(longint signed dot, longint unsigned qn,
                                    longint unsigned en);
    longint unsigned den;
    longint unsigned mag;
    longint unsigned q;
    bit neg;
    if (qn == 0 || en == 0) return 0;
    den = qn * en;
    neg = dot < 0;
    mag = neg ? longint'(-dot) : longint'(dot);
    if (mag >= den) return neg ? -32768 : 32767;
    q = (mag << FRAC_BITS) / den;
    return neg ? -int'(q) : int'(q);
  endfunction

  function automatic void push_status(logic [2:0] st);
    rsp_t s;
    s.status = st;
    s.match_id = '0;
    s.match_score = '0;
    s.last_result = 1'b1;
    rsp_due.push_back(s);
  endfunction

  task automatic absorb(req_t r);
    longint signed e;
    int unsigned total;
    bit mism;
    longint unsigned qn;
    int unsigned k;
    int unsigned n;
    int unsigned p;
    int sc;
    longint signed dot;
    int best_sc [CSTK_MAX_K];
    int unsigned best_ix [CSTK_MAX_K];
    rsp_t m;
    e = longint'(r.element_value);
    if (pos < CSTK_MAX_DIM) begin
      qbuf[pos] = r.element_value;
      if (n_entries < CSTK_MAX_ENTRIES) vec_mem[n_entries*CSTK_MAX_DIM + pos] = r.element_value;
      sq_acc = sq_acc + SQ_W'(e * e);
      pos++;
    end else begin
      len_err = 1'b1;
    end
    if (!r.last_element) return;
    total = pos;
    mism = len_err || total != vlen_q;
    qn = root_floor(longint'(sq_acc)) & 64'hFF_FFFF;
    pos = 0;
    len_err = 1'b0;
    sq_acc = '0;
    if (r.action == ACT_ADD) begin
      if (mism) push_status(ST_MISMATCH);
      else if (n_entries >= limit_q || n_entries >= CSTK_MAX_ENTRIES) push_status(ST_FULL);
      else begin
        norm_mem[n_entries] = NORM_W'(qn);
        id_mem[n_entries] = r.entry_id;
        n_entries++;
        push_status(ST_ADDED);
      end
      return;
    end
    if (mism) begin
      push_status(ST_MISMATCH);
      return;
    end
    if (n_entries == 0) begin
      push_status(ST_EMPTY);
      return;
    end
    k = (r.top_k == 0) ? 1 : r.top_k;
    if (k > CSTK_MAX_K) k = CSTK_MAX_K;
    if (k > n_entries) k = n_entries;
    n = 0;
    for (int unsigned i = 0; i < n_entries; i++) begin
      dot = 0;
      for (int unsigned j = 0; j < total; j++)
        dot += longint'(qbuf[j]) * longint'(vec_mem[i*CSTK_MAX_DIM + j]);
      sc = cosine_q15(dot, qn, longint'(norm_mem[i]));
      p = 0;
      while (p < n && best_sc[p] >= sc) p++;
      if (p < k) begin
        if (n < k) n++;
        for (int unsigned j = n - 1; j > p; j--) begin
          best_sc[j] = best_sc[j-1];
          best_ix[j] = best_ix[j-1];
        end
        best_sc[p] = sc;
        best_ix[p] = i;
      end
    end
    for (int unsigned i = 0; i < n; i++) begin
      m.status = ST_MATCH;
      m.match_id = id_mem[best_ix[i]];
      m.match_score = ELEM_W'(best_sc[i]);
      m.last_result = (i + 1 == n);
      rsp_due.push_back(m);
    end
  endtask

  always @(posedge clk) begin
    rsp_t x;
    if (rst) begin
      n_entries = 0;
      pos = 0;
      len_err = 1'b0;
      sq_acc = '0;
      vlen_q = VLEN_RESET;
      limit_q = LIMIT_RESET;
      rsp_due.delete();
      err_cnt = 0;
      rsp_cnt = 0;
    end else begin
      if (result_valid) begin
        rsp_cnt++;
        if (rsp_due.size() == 0) begin
          err_cnt++;
          $display("%0t unexpected result: got %p", $time, result);
        end else begin
          x = rsp_due.pop_front();
          if (result.status !== x.status || result.match_id !== x.match_id ||
              result.match_score !== x.match_score ||
              result.last_result !== x.last_result) begin
            err_cnt++;
            $display("%0t result mismatch: expected %p actual %p", $time, x, result);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_VLEN) vlen_q = pwdata[6:0];
        else limit_q = pwdata[8:0];
      end
      if (start && !busy) absorb(request);
    end
    errors <= err_cnt;
    pending <= rsp_due.size();
    results_seen <= rsp_cnt;
  end

endmodule

/* tb/tb_cosine_similarity_top_k_search.sv */
// testbench top: drives vectors and register writes into the top-k search block, gives the verdict
`timescale 1ns / 1ps
module tb_cosine_similarity_top_k_search;
  import cstk_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        request;
  logic        result_valid;
  rsp_t        result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          results_seen;

  logic signed [15:0] vbuf [80];
  logic signed [15:0] last_add [64];
  int idle_pct;
  int elems_sent;
  int vectors_sent;
  int vlen_cur;

  cosine_similarity_top_k_search u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cstk_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic drive_elem(req_t r);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    elems_sent++;
  endtask

  // mixed: action of every element random, the last one decides
  task automatic send_vector(logic act, int n, logic [31:0] id, logic [6:0] k, bit mixed);
    req_t r;
    for (int i = 0; i < n; i++) begin
      r.action = mixed ? logic'($urandom_range(1)) : act;
      r.element_value = vbuf[i];
      r.last_element = (i == n - 1);
      r.entry_id = mixed ? $urandom : id;
      r.top_k = mixed ? 7'($urandom) : k;
      if (i == n - 1) r.action = act;
      if (i == n - 1) r.entry_id = id;
      if (i == n - 1) r.top_k = k;
      drive_elem(r);
    end
    if (act == ACT_ADD)
      for (int i = 0; i < n && i < 64; i++) last_add[i] = vbuf[i];
    vectors_sent++;
  endtask

  // 0 random, 1 zero, 2 max, 3 min, 4 copy of last add, 5 inverse of last add, 6 sparse
  task automatic fill_vec(int mode, int n);
    for (int i = 0; i < n; i++)
      case (mode)
        0: vbuf[i] = $urandom;
        1: vbuf[i] = '0;
        2: vbuf[i] = 16'sh7FFF;
        3: vbuf[i] = -16'sh8000;
        4: vbuf[i] = (i < 64) ? last_add[i] : 16'sh0;
        5: vbuf[i] = (i < 64) ? ~last_add[i] : 16'sh0;
        default: vbuf[i] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'sh0;
      endcase
  endtask

  task automatic reg_write(logic reg_sel, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_sel, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle_and_config(int vl, int lim);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    while (busy) @(posedge clk);
    reg_write(REG_VLEN, vl);
    reg_write(REG_LIMIT, lim);
    vlen_cur = vl;
  endtask

  task automatic rand_vectors(int count, int add_pct);
    int n;
    logic act;
    logic [6:0] k;
    int pick;
    for (int v = 0; v < count; v++) begin
      act = ($urandom_range(99) < add_pct) ? ACT_ADD : ACT_QUERY;
      if ($urandom_range(99) < 85 && vlen_cur >= 1 && vlen_cur <= 64) n = vlen_cur;
      else n = $urandom_range(1, 66);
      pick = $urandom_range(99);
      if (pick < 55) fill_vec(0, n);
      else if (pick < 62) fill_vec(1, n);
      else if (pick < 67) fill_vec(2, n);
      else if (pick < 72) fill_vec(3, n);
      else if (pick < 84) fill_vec(4, n);
      else if (pick < 90) fill_vec(5, n);
      else fill_vec(6, n);
      pick = $urandom_range(99);
      if (pick < 70) k = $urandom_range(1, 8);
      else if (pick < 80) k = 0;
      else k = $urandom_range(127);
      send_vector(act, n, $urandom, k, $urandom_range(99) < 5);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    elems_sent = 0;
    vectors_sent = 0;
    for (int i = 0; i < 64; i++) last_add[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    settle_and_config(64, 2);
    fill_vec(0, 65);
    send_vector(ACT_ADD, 65, 32'h1, 7'd1, 0);
    fill_vec(0, 64);
    send_vector(ACT_QUERY, 64, 32'h0, 7'd1, 0);
    fill_vec(0, 3);
    send_vector(ACT_QUERY, 3, 32'h0, 7'd1, 0);
    fill_vec(2, 64);
    send_vector(ACT_ADD, 64, 32'h7FFF_FFFF, 7'd1, 0);
    fill_vec(3, 64);
    send_vector(ACT_ADD, 64, 32'h8000_0000, 7'd1, 0);
    fill_vec(0, 64);
    send_vector(ACT_ADD, 64, 32'hFFFF_FFFF, 7'd1, 0);
    fill_vec(0, 10);
    send_vector(ACT_ADD, 10, 32'h5, 7'd1, 0);
    fill_vec(2, 64);
    send_vector(ACT_QUERY, 64, 32'h0, 7'd0, 0);
    fill_vec(2, 64);
    send_vector(ACT_QUERY, 64, 32'h0, 7'd127, 0);
    fill_vec(1, 64);
    send_vector(ACT_QUERY, 64, 32'h0, 7'd64, 0);
    fill_vec(0, 64);
    send_vector(ACT_QUERY, 64, 32'h0, 7'd2, 1);

    settle_and_config(64, 12);
    idle_pct = 0;
    rand_vectors(25, 55);
    settle_and_config(100, 12);
    idle_pct = 82;
    rand_vectors(8, 50);
    settle_and_config(8, 40);
    idle_pct = 11;
    rand_vectors(60, 55);
    settle_and_config(0, 0);
    idle_pct = 82;
    rand_vectors(8, 50);
    settle_and_config(3, 90);
    rand_vectors(80, 55);
    settle_and_config(1, 511);
    idle_pct = 0;
    rand_vectors(150, 95);
    idle_pct = 11;
    rand_vectors(150, 95);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d vectors (%0d elements) over seven register settings", vectors_sent,
             elems_sent);
    $display("checked %0d results, %0d still pending", results_seen, pending);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
